// ===== hw/rtl/tahf_pkg.sv =====
// Shared constants, widths and helpers for the temperature average block.
package tahf_pkg;

    localparam int WINDOW_LENGTH = 10;

    localparam int SAMPLE_W = 17;
    localparam int SUM_W    = 24;
    localparam int Q_W      = 18;
    localparam int CFG_W    = 17;
    localparam int IDX_W    = 3;
    localparam int PROD_W   = 2 * SUM_W;

    localparam logic signed [SAMPLE_W-1:0] RESET_READING = 17'sd2650;
    localparam logic signed [SUM_W-1:0]    SUM_RESET     = SUM_W'(2650 * WINDOW_LENGTH);
    localparam logic [SUM_W-1:0]           SUM_BIAS      = SUM_W'(WINDOW_LENGTH * 65536);
    localparam logic [SUM_W-1:0]           WINDOW_L      = SUM_W'(WINDOW_LENGTH);
    localparam logic [SUM_W-1:0]           RECIP         = SUM_W'((1 << SUM_W) / WINDOW_LENGTH);

    localparam logic signed [SAMPLE_W-1:0] S17_MAX = 17'sd65535;
    localparam logic signed [SAMPLE_W-1:0] S17_MIN = -17'sd65536;

    localparam logic [IDX_W-1:0] REG_SAMPLE_OFFSET = 3'd0;
    localparam logic [IDX_W-1:0] REG_AVG_CORRECT   = 3'd1;
    localparam logic [IDX_W-1:0] REG_FEVER_SET     = 3'd2;
    localparam logic [IDX_W-1:0] REG_FEVER_CLEAR   = 3'd3;
    localparam logic [IDX_W-1:0] REG_WEAR_SET      = 3'd4;
    localparam logic [IDX_W-1:0] REG_WEAR_CLEAR    = 3'd5;

    function automatic logic signed [SAMPLE_W-1:0] sat17(input logic signed [SAMPLE_W:0] v);
        logic signed [SAMPLE_W-1:0] res;
        if (v[SAMPLE_W] != v[SAMPLE_W-1])
        begin
            res = v[SAMPLE_W] ? S17_MIN : S17_MAX;
        end
        else
        begin
            res = v[SAMPLE_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/tahf_cell.sv =====
// One slot of the reading chain: holds a reading and passes it on each shift.
module tahf_cell
    import tahf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       shift,
    input  logic signed [SAMPLE_W-1:0] d,
    output logic signed [SAMPLE_W-1:0] q
);

    logic signed [SAMPLE_W-1:0] data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= RESET_READING;
        end
        else if (shift)
        begin
            data_reg <= d;
        end
    end

    assign q = data_reg;

endmodule

// ===== hw/rtl/tahf_mean.sv =====
// Pipelined floor division of the biased ring sum by the window length, plus correction.
module tahf_mean
    import tahf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       sum_valid,
    output logic                       sum_ready,
    input  logic [SUM_W-1:0]           biased_sum,
    input  logic signed [9:0]          correction,
    output logic                       avg_valid,
    input  logic                       avg_ready,
    output logic signed [SAMPLE_W-1:0] avg
);

    logic                       v2_reg, v3_reg, v4_reg;
    logic                       ready2, ready3, ready4;
    logic [SUM_W-1:0]           u2_reg, u3_reg;
    logic [Q_W-1:0]             q2_reg, q3_reg;
    logic [SUM_W-1:0]           qw3_reg;
    logic signed [SAMPLE_W-1:0] avg4_reg;
    logic [PROD_W-1:0]          prod;
    logic [SUM_W-1:0]           rem;
    logic [Q_W-1:0]             q_fix;
    logic signed [SAMPLE_W-1:0] mean;
    logic signed [SAMPLE_W:0]   avg_wide;

    assign ready4    = !v4_reg || avg_ready;
    assign ready3    = !v3_reg || ready4;
    assign ready2    = !v2_reg || ready3;
    assign sum_ready = ready2;

    assign prod     = PROD_W'(biased_sum) * PROD_W'(RECIP);
    assign rem      = u3_reg - qw3_reg;
    assign q_fix    = q3_reg + Q_W'(rem >= WINDOW_L);
    assign mean     = signed'({~q_fix[SAMPLE_W-1], q_fix[SAMPLE_W-2:0]});
    assign avg_wide = (SAMPLE_W+1)'(mean) + (SAMPLE_W+1)'(correction);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ready2)
            begin
                v2_reg <= sum_valid;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
            if (ready4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready2 && sum_valid)
        begin
            u2_reg <= biased_sum;
            q2_reg <= prod[SUM_W +: Q_W];
        end
        if (ready3 && v2_reg)
        begin
            u3_reg  <= u2_reg;
            q3_reg  <= q2_reg;
            qw3_reg <= SUM_W'(SUM_W'(q2_reg) * WINDOW_L);
        end
        if (ready4 && v3_reg)
        begin
            avg4_reg <= sat17(avg_wide);
        end
    end

    assign avg_valid = v4_reg;
    assign avg       = avg4_reg;

endmodule

// ===== hw/rtl/tahf_hyst.sv =====
// Hysteresis flag with rising-edge alert.
module tahf_hyst
    import tahf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       update,
    input  logic signed [SAMPLE_W-1:0] avg,
    input  logic signed [CFG_W-1:0]    set_level,
    input  logic signed [CFG_W-1:0]    clear_level,
    output logic                       flag_next,
    output logic                       alert
);

    logic state_reg;

    always_comb
    begin
        if (avg > set_level)
        begin
            flag_next = 1'b1;
        end
        else if (avg < clear_level)
        begin
            flag_next = 1'b0;
        end
        else
        begin
            flag_next = state_reg;
        end
    end

    assign alert = flag_next && !state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= 1'b0;
        end
        else if (update)
        begin
            state_reg <= flag_next;
        end
    end

endmodule

// ===== hw/rtl/temperature_average_hysteresis_flags.sv =====
// Top level: temperature moving average with fever and wear hysteresis flags.
//
// Input channel: raw_sample with in_valid / in_stall; a beat moves when valid is
// high and stall low. Output channel: average_temp and the four flag bits with
// out_valid / out_stall. Exactly one result beat follows each input beat, in order.
// Each input beat shifts the offset, saturated reading into a chain of ten
// reading cells while the running sum adds the new reading and drops the one
// leaving the chain end. A three-stage reciprocal divider forms the floored mean
// and adds the correction; the output register applies both hysteresis flags.
// The result passes the sum, three divider and output registers before out_valid.
// Throughput: one beat per cycle while out_stall is low; the sum update sets that rate.
// While out_stall is high the held result stays put and earlier stages keep
// filling; in_stall rises once every stage holds a beat.
// Reset clears the pipeline, loads every reading cell with 26.50 degrees, the sum
// with the matching total, both hysteresis states with zero and the registers with defaults.
// Users must write registers via cfg_we/cfg_index/cfg_data only when idle; not enforced.
module temperature_average_hysteresis_flags
    import tahf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] raw_sample,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] average_temp,
    output logic                       fever_flag,
    output logic                       fever_alert,
    output logic                       wear_flag_out,
    output logic                       wear_alert,
    input  logic                       cfg_we,
    input  logic [IDX_W-1:0]           cfg_index,
    input  logic [CFG_W-1:0]           cfg_data
);

    logic signed [11:0]         sample_offset_reg;
    logic signed [9:0]          avg_correct_reg;
    logic signed [CFG_W-1:0]    fever_set_reg, fever_clear_reg;
    logic signed [CFG_W-1:0]    wear_set_reg, wear_clear_reg;

    logic                       in_acc;
    logic signed [SAMPLE_W:0]   sample_wide;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SAMPLE_W-1:0] tap [WINDOW_LENGTH+1];
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic [SUM_W-1:0]           u1_reg;
    logic                       s1_valid_reg, s1_ready;
    logic                       mean_ready, mean_valid;
    logic signed [SAMPLE_W-1:0] mean_avg;
    logic                       out_ready, out_load;
    logic                       fever_next, fever_rise, wear_next, wear_rise;

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] avg_reg;
    logic                       fever_flag_reg, fever_alert_reg, wear_flag_reg, wear_alert_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_offset_reg <= 12'sd500;
            avg_correct_reg   <= 10'sd10;
            fever_set_reg     <= 17'sd3850;
            fever_clear_reg   <= 17'sd3700;
            wear_set_reg      <= 17'sd3300;
            wear_clear_reg    <= 17'sd3000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SAMPLE_OFFSET: sample_offset_reg <= signed'(cfg_data[11:0]);
                REG_AVG_CORRECT:   avg_correct_reg   <= signed'(cfg_data[9:0]);
                REG_FEVER_SET:     fever_set_reg     <= signed'(cfg_data);
                REG_FEVER_CLEAR:   fever_clear_reg   <= signed'(cfg_data);
                REG_WEAR_SET:      wear_set_reg      <= signed'(cfg_data);
                REG_WEAR_CLEAR:    wear_clear_reg    <= signed'(cfg_data);
                default:           ;
            endcase
        end
    end

    assign s1_ready = !s1_valid_reg || mean_ready;
    assign in_stall = !s1_ready;
    assign in_acc   = in_valid && s1_ready;

    assign sample_wide = (SAMPLE_W+1)'(raw_sample) + (SAMPLE_W+1)'(sample_offset_reg);
    assign sample      = sat17(sample_wide);
    assign tap[0]      = sample;

    for (genvar i = 0; i < WINDOW_LENGTH; i++)
    begin : g_cell
        tahf_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (in_acc),
            .d     (tap[i]),
            .q     (tap[i+1])
        );
    end

    assign sum_next = sum_reg + SUM_W'(sample) - SUM_W'(tap[WINDOW_LENGTH]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg      <= SUM_RESET;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                sum_reg <= sum_next;
            end
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            u1_reg <= unsigned'(sum_next) + SUM_BIAS;
        end
    end

    tahf_mean u_mean (
        .clk        (clk),
        .rst_n      (rst_n),
        .sum_valid  (s1_valid_reg),
        .sum_ready  (mean_ready),
        .biased_sum (u1_reg),
        .correction (avg_correct_reg),
        .avg_valid  (mean_valid),
        .avg_ready  (out_ready),
        .avg        (mean_avg)
    );

    assign out_ready = !out_valid_reg || !out_stall;
    assign out_load  = mean_valid && out_ready;

    tahf_hyst u_fever (
        .clk         (clk),
        .rst_n       (rst_n),
        .update      (out_load),
        .avg         (mean_avg),
        .set_level   (fever_set_reg),
        .clear_level (fever_clear_reg),
        .flag_next   (fever_next),
        .alert       (fever_rise)
    );

    tahf_hyst u_wear (
        .clk         (clk),
        .rst_n       (rst_n),
        .update      (out_load),
        .avg         (mean_avg),
        .set_level   (wear_set_reg),
        .clear_level (wear_clear_reg),
        .flag_next   (wear_next),
        .alert       (wear_rise)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= mean_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            avg_reg         <= mean_avg;
            fever_flag_reg  <= fever_next;
            fever_alert_reg <= fever_rise;
            wear_flag_reg   <= wear_next;
            wear_alert_reg  <= wear_rise;
        end
    end

    assign out_valid     = out_valid_reg;
    assign average_temp  = avg_reg;
    assign fever_flag    = fever_flag_reg;
    assign fever_alert   = fever_alert_reg;
    assign wear_flag_out = wear_flag_reg;
    assign wear_alert    = wear_alert_reg;

    a_sum_moves_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(sum_reg) |-> $past(in_acc))
        else $error("running sum changed without an input beat");

    a_alert_with_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((!fever_alert || fever_flag) && (!wear_alert || wear_flag_out)))
        else $error("alert raised without its flag");

    a_empty_front_takes: assert property (@(posedge clk) disable iff (!rst_n)
        (!s1_valid_reg && !$past(in_acc)) |-> !in_stall)
        else $error("input stalled with an empty first stage");

endmodule
